### rtl/core/ptc_pkg.sv
package ptc_pkg;

    localparam int TIME_W  = 48;
    localparam int P_W     = 17;
    localparam int CFG_W   = 27;
    localparam int IDX_W   = 3;
    localparam int OFS_W   = 15;
    localparam int INT_W   = 22;
    localparam int WIN_W   = 27;
    localparam int RATE_W  = 14;
    localparam int TREND_W = 2;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF  = 12;

    localparam logic [INT_W-1:0]  HOUR_MS = 22'd3600000;
    localparam logic [P_W-1:0]    P_MAX   = '1;

    localparam logic [OFS_W-1:0]  OFFSET_RST   = '0;
    localparam logic [INT_W-1:0]  INTERVAL_RST = 22'd300000;
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 27'd3600000;
    localparam logic [RATE_W-1:0] RATE_RST     = 14'd200;
    localparam logic [RATE_W-1:0] TOTAL_RST    = 14'd60;
    localparam logic [RATE_W-1:0] SPREAD_RST   = 14'd100;

    typedef enum logic [IDX_W-1:0] {
        REG_OFFSET   = 3'd0,
        REG_INTERVAL = 3'd1,
        REG_WINDOW   = 3'd2,
        REG_RATE     = 3'd3,
        REG_TOTAL    = 3'd4,
        REG_SPREAD   = 3'd5
    } reg_idx_t;

    typedef enum logic [TREND_W-1:0] {
        TREND_STEADY   = 2'd0,
        TREND_RISING   = 2'd1,
        TREND_FALLING  = 2'd2,
        TREND_UNSTEADY = 2'd3
    } trend_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] time_ms;
        logic [P_W-1:0]    press;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
        logic drop_en;
    } cell_ctrl_t;

endpackage

### rtl/core/pressure_trend_classifier_unit.sv
// Pressure trend classifier.
// Input words (in_valid/in_ready) carry a timestamp, a pressure sample and an
// atmospheric flag. Words without the flag are taken and dropped. Each other
// word gives one output word (out_valid/out_ready): corrected pressure, the
// current trend and a flag set when a bucket closed on that word.
// A word that closes no bucket passes the accumulate step and goes to the
// output step. A word that closes a bucket is accumulated, averaged in the
// serial divider, then the buckets that fell out of the window are dropped
// one per cycle, the new bucket is pushed, the bucket chain is rotated once
// past the trend logic, and the drain and mean steps set the trend before
// the output step. One word is in work at a time;
// in_ready is high only while the block waits for a word.
// A finished word sits in the output register; the next word is accepted
// meanwhile, and its result waits until the receiver takes the first.
// Reset empties the bucket chain and the open bucket, sets the trend to
// steady and loads the register defaults. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong between words.
module pressure_trend_classifier_unit #(
    parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH_DEF,
    parameter int COUNT_BITS  = ptc_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptc_pkg::TIME_W-1:0]    sample_time_ms,
    input  logic [ptc_pkg::P_W-1:0]       pressure_in,
    input  logic                          source_is_atmospheric,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptc_pkg::P_W-1:0]       pressure_out,
    output logic [ptc_pkg::TREND_W-1:0]   trend_code,
    output logic                          trend_updated
);

    localparam int TW    = ptc_pkg::TIME_W;
    localparam int PW    = ptc_pkg::P_W;
    localparam int SUM_W = PW + COUNT_BITS;
    localparam int NUM_W = SUM_W + 1;
    localparam int N_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WC_W  = $clog2(QUEUE_DEPTH);
    localparam int ACC_W = PW + N_W + 2;
    localparam int PS_W  = PW + N_W;
    localparam int SP_W  = ptc_pkg::RATE_W + N_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ACC   = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_DROP  = 9'b000001000,
        S_WALK  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_MEAN1 = 9'b001000000,
        S_MEAN2 = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [ptc_pkg::OFS_W-1:0] offset_reg;
    logic [ptc_pkg::INT_W-1:0]        interval_reg;
    logic [ptc_pkg::WIN_W-1:0]        window_reg;
    logic [ptc_pkg::RATE_W-1:0]       rate_reg;
    logic [ptc_pkg::RATE_W-1:0]       total_reg;
    logic [ptc_pkg::RATE_W-1:0]       spread_reg;

    logic [TW-1:0]         t_reg;
    logic [PW-1:0]         pin_reg;
    logic [PW-1:0]         press_reg;
    logic [PW-1:0]         avg_reg;
    logic [TW-1:0]         last_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  updated_reg;
    logic                  win_ok_reg;
    logic [TW-1:0]         win_thr_reg;
    ptc_pkg::trend_t       trend_reg;

    logic                  out_valid_reg;
    logic [PW-1:0]         out_press_reg;
    ptc_pkg::trend_t       out_trend_reg;
    logic                  out_upd_reg;

    // chain
    ptc_pkg::entry_t       cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hits;
    ptc_pkg::cell_ctrl_t   ctrl;
    ptc_pkg::entry_t       push_entry;
    logic                  any_hit;

    // walk
    logic [WC_W-1:0]       walk_cnt_reg;
    logic [TW-1:0]         prev_t_reg;
    logic [PW-1:0]         prev_p_reg;
    logic                  have_prev_reg;
    logic                  s1_v_reg;
    logic                  s1_pair_reg;
    logic signed [63:0]    s1_lhs_reg;
    logic signed [63:0]    s1_rhs_reg;
    logic signed [PW:0]    s1_d_reg;
    logic [PS_W-1:0]       psum_reg;
    logic [PW-1:0]         lo_reg;
    logic [PW-1:0]         hi_reg;
    logic [N_W-1:0]        n_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                  run_reg;
    logic                  dec_reg;
    ptc_pkg::trend_t       res_reg;
    logic [PS_W-1:0]       lon_reg;
    logic [PS_W-1:0]       hin_reg;
    logic [SP_W-1:0]       spn_reg;

    // ACC stage logic
    logic signed [PW+1:0]  p_ext;
    logic [PW-1:0]         p_sat;
    logic [TW-1:0]         int_ext;
    logic [TW-1:0]         t_m_int;
    logic                  t_ge_int;
    logic                  gap;
    logic [SUM_W-1:0]      sum_base;
    logic [COUNT_BITS-1:0] cnt_base;
    logic [SUM_W-1:0]      sum_acc;
    logic [COUNT_BITS-1:0] cnt_acc;
    logic                  closed;
    logic [NUM_W-1:0]      div_num;
    logic [COUNT_BITS-1:0] div_den;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;

    // walk stage logic
    ptc_pkg::entry_t       head;
    logic signed [PW:0]    d;
    logic signed [40:0]    d_w;
    logic signed [40:0]    h_w;
    logic signed [40:0]    lhs;
    logic [TW-1:0]         dt;
    logic [61:0]           rhs;
    logic signed [ACC_W-1:0] acc_add;
    logic signed [ACC_W-1:0] tot;
    logic                  rise_ok;
    logic                  fall_ok;
    logic                  unsteady;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= signed'(ptc_pkg::OFFSET_RST);
            interval_reg <= ptc_pkg::INTERVAL_RST;
            window_reg   <= ptc_pkg::WINDOW_RST;
            rate_reg     <= ptc_pkg::RATE_RST;
            total_reg    <= ptc_pkg::TOTAL_RST;
            spread_reg   <= ptc_pkg::SPREAD_RST;
        end
        else if (cfg_we)
        begin
            case (ptc_pkg::reg_idx_t'(cfg_index))
                ptc_pkg::REG_OFFSET:   offset_reg   <= signed'(cfg_data[ptc_pkg::OFS_W-1:0]);
                ptc_pkg::REG_INTERVAL: interval_reg <= cfg_data[ptc_pkg::INT_W-1:0];
                ptc_pkg::REG_WINDOW:   window_reg   <= cfg_data[ptc_pkg::WIN_W-1:0];
                ptc_pkg::REG_RATE:     rate_reg     <= cfg_data[ptc_pkg::RATE_W-1:0];
                ptc_pkg::REG_TOTAL:    total_reg    <= cfg_data[ptc_pkg::RATE_W-1:0];
                ptc_pkg::REG_SPREAD:   spread_reg   <= cfg_data[ptc_pkg::RATE_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        p_ext    = signed'({2'b00, pin_reg}) + (PW+2)'(offset_reg);
        if (p_ext[PW+1])
        begin
            p_sat = '0;
        end
        else if (p_ext[PW])
        begin
            p_sat = ptc_pkg::P_MAX;
        end
        else
        begin
            p_sat = p_ext[PW-1:0];
        end
        int_ext  = TW'(interval_reg);
        t_ge_int = t_reg >= int_ext;
        t_m_int  = t_reg - int_ext;
        gap      = t_ge_int && (last_reg < t_m_int);
        sum_base = gap ? '0 : sum_reg;
        cnt_base = gap ? '0 : cnt_reg;
        if (&cnt_base)
        begin
            sum_acc = sum_base;
            cnt_acc = cnt_base;
        end
        else
        begin
            sum_acc = sum_base + SUM_W'(p_sat);
            cnt_acc = cnt_base + 1'b1;
        end
        closed   = gap || !cells[0].valid || (t_ge_int && (cells[0].time_ms <= t_m_int));
        div_num  = {1'b0, sum_acc} + NUM_W'(cnt_acc >> 1);
        div_den  = (cnt_acc == '0) ? COUNT_BITS'(1) : cnt_acc;
        div_start = (state_reg == S_ACC) && closed;
    end

    ptc_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign any_hit = |hits;

    always_comb
    begin
        ctrl.clear   = (state_reg == S_ACC) && gap;
        ctrl.drop_en = (state_reg == S_DROP) && win_ok_reg;
        ctrl.shift   = (state_reg == S_DROP) && !any_hit;
        ctrl.rotate  = (state_reg == S_WALK);
        push_entry.valid   = 1'b1;
        push_entry.time_ms = t_reg;
        push_entry.press   = avg_reg;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        ptc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .thr        (win_thr_reg),
            .left       ((i == 0) ? push_entry : cells[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
            .right      (cells[(i + 1) % QUEUE_DEPTH]),
            .next_valid ((i == QUEUE_DEPTH - 1) ? 1'b0 : cells[(i + 1) % QUEUE_DEPTH].valid),
            .entry      (cells[i]),
            .drop_hit   (hits[i])
        );
    end

    always_comb
    begin
        head    = cells[0];
        d       = signed'({1'b0, prev_p_reg}) - signed'({1'b0, head.press});
        d_w     = 41'(d);
        h_w     = 41'(signed'({1'b0, ptc_pkg::HOUR_MS}));
        lhs     = d_w * h_w;
        dt      = (prev_t_reg >= head.time_ms) ? (prev_t_reg - head.time_ms) : '0;
        rhs     = 62'(rate_reg) * 62'(dt);
        acc_add = acc_reg + ACC_W'(s1_d_reg);
        tot     = signed'(ACC_W'(total_reg));
        rise_ok = !acc_reg[ACC_W-1] && (s1_lhs_reg >= s1_rhs_reg);
        fall_ok = (acc_reg <= 0) && (s1_lhs_reg <= -s1_rhs_reg);
        unsteady = (n_reg != '0) &&
                   (((psum_reg - lon_reg) >= PS_W'(spn_reg)) ||
                    ((hin_reg - psum_reg) >= PS_W'(spn_reg)));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid && source_is_atmospheric) state_next = S_ACC;
            S_ACC:   state_next = closed ? S_DIV : S_OUT;
            S_DIV:   if (div_done) state_next = S_DROP;
            S_DROP:  if (!any_hit) state_next = S_WALK;
            S_WALK:  if (walk_cnt_reg == WC_W'(QUEUE_DEPTH - 1)) state_next = S_DRAIN;
            S_DRAIN: state_next = S_MEAN1;
            S_MEAN1: state_next = S_MEAN2;
            S_MEAN2: state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            trend_reg     <= ptc_pkg::TREND_STEADY;
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= (state_reg == S_WALK) && head.valid;
            if (state_reg == S_ACC)
            begin
                last_reg <= t_reg;
                sum_reg  <= closed ? '0 : sum_acc;
                cnt_reg  <= closed ? '0 : cnt_acc;
            end
            if (state_reg == S_MEAN2)
            begin
                trend_reg <= dec_reg ? res_reg :
                             (unsteady ? ptc_pkg::TREND_UNSTEADY : ptc_pkg::TREND_STEADY);
            end
            if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            t_reg   <= sample_time_ms;
            pin_reg <= pressure_in;
        end
        if (state_reg == S_ACC)
        begin
            press_reg   <= p_sat;
            updated_reg <= closed;
            win_ok_reg  <= t_reg >= TW'(window_reg);
            win_thr_reg <= t_reg - TW'(window_reg);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            avg_reg <= div_quo[PW-1:0];
        end
        if ((state_reg == S_DROP) && !any_hit)
        begin
            walk_cnt_reg  <= '0;
            have_prev_reg <= 1'b0;
            psum_reg      <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            run_reg       <= 1'b1;
            dec_reg       <= 1'b0;
            res_reg       <= ptc_pkg::TREND_STEADY;
        end
        if (state_reg == S_WALK)
        begin
            walk_cnt_reg <= walk_cnt_reg + 1'b1;
            if (head.valid)
            begin
                s1_pair_reg   <= have_prev_reg;
                s1_d_reg      <= d;
                s1_lhs_reg    <= 64'(lhs);
                s1_rhs_reg    <= signed'({2'b00, rhs});
                prev_t_reg    <= head.time_ms;
                prev_p_reg    <= head.press;
                have_prev_reg <= 1'b1;
                psum_reg      <= psum_reg + PS_W'(head.press);
                n_reg         <= n_reg + 1'b1;
                if (!have_prev_reg || (head.press < lo_reg))
                begin
                    lo_reg <= head.press;
                end
                if (!have_prev_reg || (head.press > hi_reg))
                begin
                    hi_reg <= head.press;
                end
            end
        end
        if (s1_v_reg && s1_pair_reg && run_reg && !dec_reg)
        begin
            if (rise_ok)
            begin
                acc_reg <= acc_add;
                if (acc_add >= tot)
                begin
                    dec_reg <= 1'b1;
                    res_reg <= ptc_pkg::TREND_RISING;
                end
            end
            else if (fall_ok)
            begin
                acc_reg <= acc_add;
                if (acc_add <= -tot)
                begin
                    dec_reg <= 1'b1;
                    res_reg <= ptc_pkg::TREND_FALLING;
                end
            end
            else
            begin
                run_reg <= 1'b0;
            end
        end
        if (state_reg == S_MEAN1)
        begin
            lon_reg <= PS_W'(lo_reg) * PS_W'(n_reg);
            hin_reg <= PS_W'(hi_reg) * PS_W'(n_reg);
            spn_reg <= SP_W'(spread_reg) * SP_W'(n_reg);
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            out_press_reg <= press_reg;
            out_trend_reg <= trend_reg;
            out_upd_reg   <= updated_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pressure_out  = out_press_reg;
    assign trend_code    = out_trend_reg;
    assign trend_updated = out_upd_reg;

endmodule

### rtl/core/ptc_cell.sv
module ptc_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ptc_pkg::cell_ctrl_t                ctrl,
    input  logic [ptc_pkg::TIME_W-1:0]         thr,
    input  ptc_pkg::entry_t                    left,
    input  ptc_pkg::entry_t                    right,
    input  logic                               next_valid,
    output ptc_pkg::entry_t                    entry,
    output logic                               drop_hit
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ptc_pkg::TIME_W-1:0]  time_reg;
    logic [ptc_pkg::TIME_W-1:0]  time_next;
    logic [ptc_pkg::P_W-1:0]     press_reg;
    logic [ptc_pkg::P_W-1:0]     press_next;

    assign drop_hit = ctrl.drop_en && valid_reg && !next_valid && (time_reg <= thr);

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        press_next = press_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = left.valid;
            time_next  = left.time_ms;
            press_next = left.press;
        end
        else if (ctrl.rotate)
        begin
            valid_next = right.valid;
            time_next  = right.time_ms;
            press_next = right.press;
        end
        else if (drop_hit)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        press_reg <= press_next;
    end

    assign entry.valid   = valid_reg;
    assign entry.time_ms = time_reg;
    assign entry.press   = press_reg;

endmodule

### rtl/core/ptc_div.sv
module ptc_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W:0]   rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
